[rtl/osat_pkg.sv]
`default_nettype none
package osat_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned EMPH_W   = 30;
  localparam int unsigned NUM_W    = 47;
  localparam int unsigned DEN_W    = 25;
  localparam int unsigned QUO_W    = 24;
  localparam int unsigned ATAN_W   = 27;
  localparam int unsigned CARG_W   = 33;

  localparam logic [23:0] ONE_Q23 = 24'd8388608;
  localparam logic [22:0] LN2_Q23 = 23'd5814541;
  localparam logic [15:0] K_06    = 16'd39322;
  localparam logic [16:0] K_08    = 17'd52429;
  localparam logic [15:0] K_015   = 16'd9830;
  localparam logic [15:0] K_075   = 16'd49152;
  localparam logic [15:0] K_04    = 16'd26214;
  localparam logic [15:0] K_035   = 16'd22938;
  localparam logic [15:0] K_02    = 16'd13107;
  localparam logic [16:0] UNIT    = 17'd65536;

  localparam logic [2:0] REG_DRIVE = 3'd0;
  localparam logic [2:0] REG_COLOR = 3'd1;
  localparam logic [2:0] REG_BIAS  = 3'd2;
  localparam logic [2:0] REG_DYN   = 3'd3;
  localparam logic [2:0] REG_SLEW  = 3'd4;
  localparam logic [2:0] REG_MIX   = 3'd5;
  localparam logic [2:0] REG_TRIM  = 3'd6;
  localparam logic [2:0] REG_OVS4  = 3'd7;

  typedef struct packed {
    logic signed [29:0] last_emph;
    logic signed [23:0] hyst;
    logic signed [23:0] slew;
  } osat_entry_t;

  typedef enum logic [5:0] {
    S_IDLE, S_PRE, S_BIAS, S_DYNK, S_ASYM, S_MB, S_EMPH1, S_EMPH2,
    S_UP, S_DYN, S_B, S_TNS, S_TNW, S_TNR, S_HM, S_HDS, S_HDW, S_TES, S_TEW,
    S_AM, S_ATS, S_ATW, S_CA, S_C1, S_C2, S_H1, S_H2, S_SCS, S_SCW,
    S_S1, S_S2, S_SL, S_FIN, S_BL, S_TR, S_OUT
  } osat_state_t;

  function automatic logic [22:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  return 23'd6588397;
      5'd1:  return 23'd3889358;
      5'd2:  return 23'd2055030;
      5'd3:  return 23'd1043165;
      5'd4:  return 23'd523607;
      5'd5:  return 23'd262059;
      5'd6:  return 23'd131061;
      5'd7:  return 23'd65535;
      5'd8:  return 23'd32768;
      5'd9:  return 23'd16384;
      5'd10: return 23'd8192;
      5'd11: return 23'd4096;
      5'd12: return 23'd2048;
      5'd13: return 23'd1024;
      5'd14: return 23'd512;
      5'd15: return 23'd256;
      5'd16: return 23'd128;
      5'd17: return 23'd64;
      5'd18: return 23'd32;
      5'd19: return 23'd16;
      5'd20: return 23'd8;
      5'd21: return 23'd4;
      5'd22: return 23'd2;
      5'd23: return 23'd1;
      default: return 23'd0;
    endcase
  endfunction

  // ceil(2^27 / k); exact floor quotient for dividends below 2^23
  function automatic logic [27:0] recip_k(input logic [3:0] k);
    case (k)
      4'd1:  return 28'd134217728;
      4'd2:  return 28'd67108864;
      4'd3:  return 28'd44739243;
      4'd4:  return 28'd33554432;
      4'd5:  return 28'd26843546;
      4'd6:  return 28'd22369622;
      4'd7:  return 28'd19173962;
      4'd8:  return 28'd16777216;
      4'd9:  return 28'd14913081;
      4'd10: return 28'd13421773;
      default: return 28'd0;
    endcase
  endfunction

  function automatic logic signed [29:0] sat30(input logic signed [47:0] v);
    if (v > 48'sd536870911) begin
      return 30'sh1FFFFFFF;
    end else if (v < -48'sd536870912) begin
      return 30'sh20000000;
    end
    return v[29:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic [16:0] unit_clamp(input logic [16:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

endpackage
`default_nettype wire

[rtl/osat_div.sv]
`default_nettype none
module osat_div
  import osat_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic [QUO_W-1:0]      quot
);

  logic             run_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] lo_r;
  logic [QUO_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd1);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'(QUO_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
      lo_r  <= num[QUO_W-1:0];
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      q_r   <= {q_r[QUO_W-2:0], fits};
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

[rtl/osat_cordic.sv]
`default_nettype none
module osat_cordic
  import osat_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [CARG_W-1:0] arg,
  output logic                          busy,
  output logic                          done,
  output logic signed [ATAN_W-1:0]      angle
);

  logic                     run_r;
  logic                     done_r;
  logic [4:0]               i_r;
  logic signed [35:0]       x_r;
  logic signed [35:0]       y_r;
  logic signed [ATAN_W-1:0] z_r;
  logic signed [35:0]       xs;
  logic signed [35:0]       ys;
  logic signed [ATAN_W-1:0] tab;

  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  assign tab = $signed({4'b0, atan_tab(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= run_r && (i_r == 5'd23);
      if (start) begin
        run_r <= 1'b1;
        i_r   <= '0;
      end else if (run_r) begin
        i_r <= i_r + 5'd1;
        if (i_r == 5'd23) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= 36'sd8388608;
      y_r <= 36'(arg);
      z_r <= '0;
    end else if (run_r) begin
      if (!y_r[35]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - tab;
      end
    end
  end

  assign busy  = run_r;
  assign done  = done_r;
  assign angle = z_r;

endmodule
`default_nettype wire

[rtl/osat_state_mem.sv]
`default_nettype none
module osat_state_mem
  import osat_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output osat_entry_t        rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire osat_entry_t   wr_data
);

  osat_entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  osat_entry_t      rd_q_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule
`default_nettype wire

[rtl/oversampled_saturation_stage_top.sv]
`default_nettype none
// Per-channel oversampled saturator. One request (sample plus channel) is
// processed at a time: pre-emphasis and drive, 2x or 4x linear upsampling from
// the channel's previous emphasised value, a tanh/atan waveshaper with
// hysteresis and soft clip, a slew limiter, averaging, wet/dry mix and trim.
// The work per sub-sample is set mostly by the shared one-bit-per-cycle
// divider, used twice per sub-sample (tanh quotient, soft clip), and by a
// 24-step CORDIC. The tanh range reduction uses comparisons and the ten
// series terms use reciprocal multiplication, each stepping through S_HM,
// S_HDS and S_HDW. Channel state (last emphasised value, hysteresis memory,
// slew history) lives in a small synchronous memory read at request start
// and written back at the end; unwritten entries read as zero after reset.
// The next request is taken while a finished result waits.
module oversampled_saturation_stage_top
  import osat_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] in_sample
  input  wire logic [2:0]  in_tuser,   // [2:0] chan
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [23:0] out_sample
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [22:0] cfg_wdata
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [20:0]        drive_r;
  logic [16:0]        color_r;
  logic signed [15:0] bias_amt_r;
  logic [16:0]        dynamics_r;
  logic [22:0]        slew_step_r;
  logic [16:0]        mix_r;
  logic [19:0]        trim_r;
  logic               ovs4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r     <= 21'd65536;
      color_r     <= 17'd32768;
      bias_amt_r  <= '0;
      dynamics_r  <= 17'd32768;
      slew_step_r <= 23'd8388607;
      mix_r       <= 17'd65536;
      trim_r      <= 20'd65536;
      ovs4_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE: drive_r     <= cfg_wdata[20:0];
        REG_COLOR: color_r     <= cfg_wdata[16:0];
        REG_BIAS:  bias_amt_r  <= cfg_wdata[15:0];
        REG_DYN:   dynamics_r  <= cfg_wdata[16:0];
        REG_SLEW:  slew_step_r <= cfg_wdata[22:0];
        REG_MIX:   mix_r       <= cfg_wdata[16:0];
        REG_TRIM:  trim_r      <= cfg_wdata[19:0];
        REG_OVS4:  ovs4_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  osat_state_t state_r, state_nxt;

  logic in_acc;
  logic out_free;
  logic out_tvalid_r;
  logic [23:0] out_tdata_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // channel map
  logic [AW-1:0] ch_idx;
  always_comb begin
    ch_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_tuser == 3'(i)) begin
        ch_idx = AW'(i % CHANNELS);
      end
    end
  end

  // datapath registers
  logic [AW-1:0]      idx_r;
  logic signed [23:0] dry_r;
  logic [16:0]        c_r, d_r, mx_r;
  logic               k4_r;
  logic [16:0]        coef_r, asym_r;
  logic [15:0]        dk_r, mb_r;
  logic signed [24:0] bias_r;
  logic signed [25:0] e1_r;
  logic signed [29:0] emph_r, prev_r, up_r, b_r;
  logic signed [23:0] hm_r, sp_r, dyn_r, soft_r, res_r;
  logic [2:0]         f_r;
  logic               tneg_r, nbig_r;
  logic [30:0]        t_r;
  logic [4:0]         n_r;
  logic [22:0]        r_r;
  logic [23:0]        p_r, hq_r, hdq_r;
  logic [3:0]         k_r;
  logic signed [24:0] th_r;
  logic signed [32:0] a_r;
  logic signed [26:0] at_r, atp_r, shaped_r;
  logic signed [42:0] m1_r, s1_r;
  logic signed [41:0] h1_r;
  logic signed [25:0] comb_r, acc_r, bl1_r;
  logic signed [26:0] blend_r;

  // shared units
  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [QUO_W-1:0] div_quot;
  logic             cor_start, cor_busy, cor_done;
  logic signed [ATAN_W-1:0] cor_angle;

  osat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  osat_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .arg   (a_r),
    .busy  (cor_busy),
    .done  (cor_done),
    .angle (cor_angle)
  );

  logic        mem_rd_en, mem_wr_en;
  osat_entry_t mem_rd_data, mem_wr_data;

  osat_state_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (ch_idx),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (mem_wr_data)
  );

  assign mem_wr_data.last_emph = emph_r;
  assign mem_wr_data.hyst      = hm_r;
  assign mem_wr_data.slew      = sp_r;

  // arithmetic
  logic [16:0]        sm_a;
  logic [15:0]        sm_b;
  logic [32:0]        sm_p;
  logic signed [32:0] bias_p;
  logic signed [41:0] emph1_p;
  logic signed [47:0] emph2_p;
  logic signed [30:0] ediff;
  logic signed [34:0] ef, ef_sh;
  logic signed [40:0] dyn_p;
  logic signed [30:0] bw;
  logic [30:0]        babs;
  logic [4:0]         n_cnt;
  logic               n_big;
  logic [46:0]        horner_p;
  logic [50:0]        hd_p;
  logic [23:0]        e_w;
  logic [17:0]        am_f;
  logic signed [48:0] am_p;
  logic signed [44:0] ca_p, c2_p;
  logic signed [42:0] hb_p;
  logic [24:0]        cabs;
  logic signed [39:0] s2_p;
  logic signed [27:0] delta, stp;
  logic signed [27:0] dclamp;
  logic signed [23:0] slew_new;
  logic signed [23:0] wet;
  logic signed [24:0] wdiff;
  logic signed [42:0] bl_p;
  logic signed [47:0] tr_p;

  always_comb begin
    case (state_r)
      S_DYNK:  begin sm_a = d_r; sm_b = K_075; end
      S_ASYM:  begin sm_a = c_r; sm_b = K_06;  end
      S_MB:    begin sm_a = d_r; sm_b = K_04;  end
      default: begin sm_a = c_r; sm_b = K_08[15:0]; end
    endcase
  end

  // range reduction: n = floor(t / ln2) by threshold compare, capped at 23
  always_comb begin
    n_cnt = '0;
    for (int j = 1; j < 24; j++) begin
      if (t_r >= 31'(j) * 31'(LN2_Q23)) begin
        n_cnt = 5'(j);
      end
    end
  end

  assign n_big    = t_r >= 31'(24) * 31'(LN2_Q23);
  assign sm_p     = sm_a * sm_b;
  assign bias_p   = bias_amt_r * $signed(K_08);
  assign emph1_p  = dry_r * $signed({1'b0, coef_r});
  assign emph2_p  = e1_r * $signed({1'b0, drive_r});
  assign ediff    = 31'(emph_r) - 31'(prev_r);
  assign ef       = ediff * $signed({1'b0, f_r});
  assign ef_sh    = k4_r ? (ef >>> 2) : (ef >>> 1);
  assign dyn_p    = hm_r * $signed({1'b0, dk_r});
  assign bw       = 31'(b_r);
  assign babs     = bw[30] ? 31'(-bw) : 31'(bw);
  assign horner_p = r_r * p_r;
  assign hd_p     = hq_r[22:0] * recip_k(k_r);
  assign e_w      = nbig_r ? 24'd0 : (p_r >> n_r);
  assign am_f     = 18'(UNIT) + {asym_r, 1'b0};
  assign am_p     = b_r * $signed({1'b0, am_f});
  assign ca_p     = at_r * $signed({1'b0, asym_r});
  assign c2_p     = atp_r * $signed({1'b0, c_r});
  assign hb_p     = comb_r * $signed({1'b0, mb_r});
  assign cabs     = comb_r[25] ? 25'(-comb_r) : 25'(comb_r);
  assign s2_p     = soft_r * $signed({1'b0, K_02});
  assign delta    = 28'(shaped_r) - 28'(sp_r);
  assign stp      = $signed({5'b0, slew_step_r});
  assign dclamp   = (delta > stp) ? stp : ((delta < -stp) ? -stp : delta);
  assign slew_new = sat24(48'(28'(sp_r) + dclamp));
  assign wet      = k4_r ? 24'(acc_r >>> 2) : 24'(acc_r >>> 1);
  assign wdiff    = 25'(wet) - 25'(dry_r);
  assign bl_p     = wdiff * $signed({1'b0, mx_r});
  assign tr_p     = blend_r * $signed({1'b0, trim_r});

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dry_r <= in_tdata;
          idx_r <= ch_idx;
          c_r   <= unit_clamp(color_r);
          d_r   <= unit_clamp(dynamics_r);
          mx_r  <= unit_clamp(mix_r);
          k4_r  <= ovs4_r;
        end
      end
      S_PRE: begin
        coef_r <= 17'(K_06) + 17'(sm_p[32:16]);
        prev_r <= mem_rd_data.last_emph;
        hm_r   <= mem_rd_data.hyst;
        sp_r   <= mem_rd_data.slew;
        acc_r  <= '0;
        f_r    <= 3'd1;
      end
      S_BIAS:  bias_r <= 25'(bias_p >>> 8);
      S_DYNK:  dk_r <= K_015 + sm_p[31:16];
      S_ASYM:  asym_r <= 17'(K_04) + 17'(sm_p[32:16]);
      S_MB:    mb_r <= K_035 + sm_p[31:16];
      S_EMPH1: e1_r <= 26'(emph1_p >>> 16);
      S_EMPH2: emph_r <= sat30(48'(emph2_p >>> 16));
      S_UP:    up_r <= 30'(35'(prev_r) + ef_sh);
      S_DYN:   dyn_r <= 24'(dyn_p >>> 16);
      S_B:     b_r <= sat30(48'(up_r) + 48'(bias_r) + 48'(dyn_r));
      S_TNS: begin
        tneg_r <= b_r[29];
        t_r    <= {babs[29:0], 1'b0};
      end
      S_TNW: begin
        nbig_r <= n_big;
        n_r    <= n_cnt;
        p_r    <= ONE_Q23;
        k_r    <= 4'd10;
      end
      S_TNR:   r_r <= 23'(t_r - 31'(n_r) * 31'(LN2_Q23));
      S_HM:    hq_r <= horner_p[46:23];
      S_HDS:   hdq_r <= 24'(hd_p >> 27);
      S_HDW: begin
        p_r <= ONE_Q23 - hdq_r;
        k_r <= k_r - 4'd1;
      end
      S_TEW: begin
        if (div_done) begin
          th_r <= tneg_r ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        end
      end
      S_AM:    a_r <= 33'(am_p >>> 16);
      S_ATW: begin
        if (cor_done) begin
          at_r <= cor_angle;
        end
      end
      S_CA:    atp_r <= 27'(ca_p >>> 16);
      S_C1:    m1_r <= th_r * $signed({1'b0, 17'(UNIT - c_r)});
      S_C2:    comb_r <= 26'((46'(m1_r) + 46'(c2_p)) >>> 16);
      S_H1:    h1_r <= hm_r * $signed({1'b0, 17'(UNIT - 17'(mb_r))});
      S_H2:    hm_r <= sat24(48'((44'(h1_r) + 44'(hb_p)) >>> 16));
      S_SCW: begin
        if (div_done) begin
          soft_r <= comb_r[25] ? -$signed(div_quot) : $signed(div_quot);
        end
      end
      S_S1:    s1_r <= comb_r * $signed({1'b0, K_08});
      S_S2:    shaped_r <= 27'((45'(s1_r) + 45'(s2_p)) >>> 16);
      S_SL: begin
        sp_r  <= slew_new;
        acc_r <= acc_r + 26'(slew_new);
        f_r   <= f_r + 3'd1;
      end
      S_FIN:   bl1_r <= 26'(bl_p >>> 16);
      S_BL:    blend_r <= 27'(dry_r) + 27'(bl1_r);
      S_TR:    res_r <= sat24(tr_p >>> 16);
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_PRE;
      S_PRE:   state_nxt = S_BIAS;
      S_BIAS:  state_nxt = S_DYNK;
      S_DYNK:  state_nxt = S_ASYM;
      S_ASYM:  state_nxt = S_MB;
      S_MB:    state_nxt = S_EMPH1;
      S_EMPH1: state_nxt = S_EMPH2;
      S_EMPH2: state_nxt = S_UP;
      S_UP:    state_nxt = S_DYN;
      S_DYN:   state_nxt = S_B;
      S_B:     state_nxt = S_TNS;
      S_TNS:   state_nxt = S_TNW;
      S_TNW:   state_nxt = S_TNR;
      S_TNR:   state_nxt = S_HM;
      S_HM:    state_nxt = S_HDS;
      S_HDS:   state_nxt = S_HDW;
      S_HDW:   state_nxt = (k_r == 4'd1) ? S_TES : S_HM;
      S_TES:   state_nxt = S_TEW;
      S_TEW:   if (div_done) state_nxt = S_AM;
      S_AM:    state_nxt = S_ATS;
      S_ATS:   state_nxt = S_ATW;
      S_ATW:   if (cor_done) state_nxt = S_CA;
      S_CA:    state_nxt = S_C1;
      S_C1:    state_nxt = S_C2;
      S_C2:    state_nxt = S_H1;
      S_H1:    state_nxt = S_H2;
      S_H2:    state_nxt = S_SCS;
      S_SCS:   state_nxt = S_SCW;
      S_SCW:   if (div_done) state_nxt = S_S1;
      S_S1:    state_nxt = S_S2;
      S_S2:    state_nxt = S_SL;
      S_SL:    state_nxt = (f_r == (k4_r ? 3'd4 : 3'd2)) ? S_FIN : S_UP;
      S_FIN:   state_nxt = S_BL;
      S_BL:    state_nxt = S_TR;
      S_TR:    state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        mem_rd_en = in_tvalid;
      end
      S_TES: begin
        div_start = 1'b1;
        div_num   = {24'(ONE_Q23 - e_w), 23'd0};
        div_den   = 25'(ONE_Q23) + 25'(e_w);
      end
      S_ATS:   cor_start = 1'b1;
      S_SCS: begin
        div_start = 1'b1;
        div_num   = {cabs[23:0], 23'd0};
        div_den   = 25'(ONE_Q23) + cabs;
      end
      S_OUT:   mem_wr_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_tdata_r <= res_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_cor_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cor_start |-> !cor_busy) else $error("cordic started while busy");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (f_r >= 3'd1 && f_r <= 3'd4))
    else $error("sub-sample index out of range");

  a_horner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDS) |-> (k_r >= 4'd1 && k_r <= 4'd10))
    else $error("series term index out of range");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_tvalid && state_r == S_IDLE))
    else $error("result not presented");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
  import osat_pkg::*;

  localparam int CHANS = 8;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [23:0] smp;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_wdata = '0;

  oversampled_saturation_stage_top #(.CHANNELS(CHANS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow registers and channel state
  longint r_drive, r_color, r_bias, r_dyn, r_slew, r_mix, r_trim, r_ovs4;
  longint m_emph[CHANS];
  longint m_hyst[CHANS];
  longint m_slew[CHANS];

  request_t        pending_q[$];
  logic [23:0]     expected_q[$];
  int              mismatches = 0;
  bit              failed = 0;
  bit              quiet = 0;
  bit              hold_off = 0;
  int              idle_cnt = 0;
  int              hold_cnt = 0;
  bit              sending = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint satw(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unit_of(longint v);
    return v > 65536 ? 65536 : v;
  endfunction

  function automatic longint tanh_q23(longint v);
    longint t, n, r, p, e, q;
    bit neg;
    neg = v < 0;
    t = 2 * (neg ? -v : v);
    n = t / 5814541;
    r = t - n * 5814541;
    p = 8388608;
    for (int k = 10; k >= 1; k--) p = 8388608 - ((r * p) >>> 23) / k;
    e = (n >= 24) ? 0 : (p >>> n);
    q = ((8388608 - e) <<< 23) / (8388608 + e);
    return neg ? -q : q;
  endfunction

  function automatic longint atan_q23(longint a);
    longint x, y, z, nx, tab;
    x = 8388608; y = a; z = 0;
    for (int i = 0; i < 24; i++) begin
      tab = longint'(atan_tab(5'(i)));
      if (y >= 0) begin
        nx = x + asr(y, i); y = y - asr(x, i); z += tab;
      end else begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= tab;
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint shaper(longint v, int ch);
    longint c, d, bias, hm, dyn, b, asym, th, at, comb, mb, sclip, mag, bs;
    c = unit_of(r_color); d = unit_of(r_dyn);
    bs = r_bias >= 32768 ? r_bias - 65536 : r_bias;
    bias = asr(bs * 52429, 8);
    hm = m_hyst[ch];
    dyn = asr(hm * (9830 + ((d * 49152) >>> 16)), 16);
    b = satw(v + bias + dyn, 30);
    asym = 26214 + ((c * 39322) >>> 16);
    th = tanh_q23(b);
    at = atan_q23(asr(b * (65536 + 2 * asym), 16));
    comb = asr(th * (65536 - c) + asr(at * asym, 16) * c, 16);
    mb = 22938 + ((d * 26214) >>> 16);
    m_hyst[ch] = satw(asr(hm * (65536 - mb) + comb * mb, 16), 24);
    mag = comb < 0 ? -comb : comb;
    sclip = (comb * 8388608) / (8388608 + mag);
    return asr(comb * 52429 + sclip * 13107, 16);
  endfunction

  function automatic longint slew_limit(longint v, int ch);
    longint delta;
    delta = v - m_slew[ch];
    if (delta > r_slew) delta = r_slew;
    if (delta < -r_slew) delta = -r_slew;
    m_slew[ch] = satw(m_slew[ch] + delta, 24);
    return m_slew[ch];
  endfunction

  function automatic logic [23:0] saturate_sample(request_t rq);
    longint dry, c, mx, emph, prev, acc, up, wet, blend;
    int k, ch;
    dry = longint'(rq.smp);
    ch = int'(rq.chan) % CHANS;
    c = unit_of(r_color); mx = unit_of(r_mix);
    k = r_ovs4[0] ? 2 : 1;
    emph = asr(dry * (39322 + ((c * 52429) >>> 16)), 16);
    emph = satw(asr(emph * r_drive, 16), 30);
    prev = m_emph[ch];
    acc = 0;
    for (int f = 1; f <= (1 << k); f++) begin
      up = prev + asr((emph - prev) * f, k);
      acc += slew_limit(shaper(up, ch), ch);
    end
    m_emph[ch] = emph;
    wet = asr(acc, k);
    blend = dry + asr((wet - dry) * mx, 16);
    return 24'(satw(asr(blend * r_trim, 16), 24));
  endfunction

  task automatic write_reg(logic [2:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= 23'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DRIVE: r_drive = val & 64'h1FFFFF;
      REG_COLOR: r_color = val & 64'h1FFFF;
      REG_BIAS:  r_bias  = val & 64'hFFFF;
      REG_DYN:   r_dyn   = val & 64'h1FFFF;
      REG_SLEW:  r_slew  = val & 64'h7FFFFF;
      REG_MIX:   r_mix   = val & 64'h1FFFF;
      REG_TRIM:  r_trim  = val & 64'hFFFFF;
      REG_OVS4:  r_ovs4  = val & 64'h1;
      default: ;
    endcase
  endtask

  task automatic push(logic signed [23:0] s, logic [2:0] ch);
    request_t rq;
    rq.smp = s; rq.chan = ch;
    pending_q.push_back(rq);
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || sending || expected_q.size() != 0) @(posedge clk);
    repeat (1700) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(saturate_sample({in_tuser, in_tdata}));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
          request_t rq;
          rq = pending_q.pop_front();
          in_tvalid <= 1'b1; in_tdata <= rq.smp; in_tuser <= rq.chan;
          sending = 1;
        end else begin
          in_tvalid <= 1'b0;
          sending = 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [23:0] e;
          e = expected_q.pop_front();
          if (e !== out_tdata) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("out_sample: expected %h got %h", e, out_tdata);
          end
        end
      end
      if (hold_off) begin
        hold_cnt++;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 6;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n
        || (pending_q.size() == 0 && expected_q.size() == 0 && !in_tvalid)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    r_drive = 65536; r_color = 32768; r_bias = 0; r_dyn = 32768;
    r_slew = 8388607; r_mix = 65536; r_trim = 65536; r_ovs4 = 0;
    for (int i = 0; i < CHANS; i++) begin
      m_emph[i] = 0; m_hyst[i] = 0; m_slew[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero and small values at reset settings
    push(24'sh7FFFFF, 3'd0); push(24'sh800000, 3'd0); push(24'sh000000, 3'd7);
    push(24'sh800000, 3'd7); push(24'sh7FFFFF, 3'd3); push(24'sh000001, 3'd5);
    push(24'shFFFFFF, 3'd5); push(24'sh400000, 3'd1);
    wait_idle();
    // extremes of every register but the slew step, 4x
    write_reg(REG_DRIVE, 2097151); write_reg(REG_COLOR, 131071);
    write_reg(REG_BIAS, 32767);    write_reg(REG_DYN, 131071);
    write_reg(REG_SLEW, 1000);     write_reg(REG_MIX, 131071);
    write_reg(REG_TRIM, 1048575);  write_reg(REG_OVS4, 1);
    push(24'sh7FFFFF, 3'd2); push(24'sh800000, 3'd2); push(24'sh123456, 3'd4);
    push(24'sh800000, 3'd6); push(24'sh7FFFFF, 3'd6);
    wait_idle();
    write_reg(REG_DRIVE, 0); write_reg(REG_COLOR, 0); write_reg(REG_BIAS, 32768);
    write_reg(REG_DYN, 0);   write_reg(REG_SLEW, 0);  write_reg(REG_MIX, 0);
    write_reg(REG_TRIM, 0);  write_reg(REG_OVS4, 0);
    push(24'sh7FFFFF, 3'd1); push(24'sh800000, 3'd1); push(24'sh000000, 3'd0);
    wait_idle();

    // random phases; phase 1 quiet, phase 2 has the long hold-off
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DRIVE, ph == 0 ? 65536 : $urandom_range(2097151));
      write_reg(REG_COLOR, $urandom_range(70000));
      write_reg(REG_BIAS, $urandom_range(65535));
      write_reg(REG_DYN, $urandom_range(70000));
      write_reg(REG_SLEW, ph[0] ? 8388607 : $urandom_range(8388607));
      write_reg(REG_MIX, $urandom_range(70000));
      write_reg(REG_TRIM, $urandom_range(ph == 3 ? 1048575 : 131072));
      write_reg(REG_OVS4, ph % 3 == 2);
      quiet = (ph == 1);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        push(24'($urandom), 3'($urandom_range(7)));
      end
      if (ph == 2) begin
        while (pending_q.size() > RANDOM_ITEMS / 6 - 3) @(posedge clk);
        hold_cnt = 0;
        hold_off = 1;
        while (hold_cnt < 6000) @(posedge clk);
        hold_off = 0;
      end
      wait_idle();
    end

    if (failed || expected_q.size() != 0) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end
endmodule
